// ===== rtl/scl_pkg.sv =====
// Shared constants, controller state type and command/status structs of the
// shuffled three-LCG uniform generator.
// No dependencies; every other file of the block but scl_ram imports this package.
package scl_pkg;

    // Field and state widths.
    localparam int LCG_W          = 18;
    localparam int DEV_W          = 36;
    localparam int SEED_W         = 31;
    localparam int TABLE_SIZE_DEF = 97;

    localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

    // Generator constants: x' = (MUL * x + INC) mod MOD.
    localparam longint unsigned MOD_A = 259200;
    localparam longint unsigned MUL_A = 7141;
    localparam longint unsigned INC_A = 54773;
    localparam longint unsigned MOD_B = 134456;
    localparam longint unsigned MUL_B = 8121;
    localparam longint unsigned INC_B = 28411;
    localparam longint unsigned MOD_C = 243000;
    localparam longint unsigned MUL_C = 4561;
    localparam longint unsigned INC_C = 51349;

    // Reciprocal division: quotient estimate is at most one below the true value.
    localparam int RECIP_SHIFT = 31;
    localparam int LCG_Q_W     = 14;
    localparam int PROD_W      = 48;

    // Seed reduction works on a 32-bit sum, so it needs one more shift bit.
    localparam int              SEED_SUM_W  = 32;
    localparam int              SEED_SHIFT  = 32;
    localparam int              SEED_Q_W    = 15;
    localparam longint unsigned SEED_RECIP  = (64'd1 << SEED_SHIFT) / MOD_A;

    // Slot scaling divides by the third generator's modulus.
    localparam longint unsigned SLOT_RECIP = (64'd1 << RECIP_SHIFT) / MOD_C;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_WAIT,
        ST_SEED_LOAD,
        ST_SEED_HOLD,
        ST_SEED_A1,
        ST_SEED_B,
        ST_SEED_A2,
        ST_SEED_C,
        ST_FILL_STEP,
        ST_FILL_WR,
        ST_DRAW_STEP,
        ST_DRAW_SLOT1,
        ST_DRAW_SLOT2,
        ST_DRAW_READ,
        ST_DRAW_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic load_third;
        logic step_ab;
        logic step_c;
        logic cnt_clr;
        logic fill_wr;
        logic tbl_rd;
        logic draw_done;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
    } t_dp_sts;

endpackage

// ===== rtl/scl_if.sv =====
// Channel interfaces of the generator: request, response and seed write.
// Depends on scl_pkg for the payload widths.

interface scl_req_if;
    import scl_pkg::*;
    logic valid;
    logic ready;
    logic reseed;
    modport source (output valid, output reseed, input ready);
    modport sink (input valid, input reseed, output ready);
endinterface

interface scl_rsp_if;
    import scl_pkg::*;
    logic             valid;
    logic             ready;
    logic [DEV_W-1:0] deviate_numerator;
    modport source (output valid, output deviate_numerator, input ready);
    modport sink (input valid, input deviate_numerator, output ready);
endinterface

interface scl_cfg_if;
    import scl_pkg::*;
    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] seed_magnitude;
    modport source (output valid, output seed_magnitude, input ready);
    modport sink (input valid, input seed_magnitude, output ready);
endinterface

// ===== rtl/shuffled_combined_lcg_uniform_unit.sv =====
// Top level of the shuffled three-LCG uniform generator.
// Depends on scl_pkg, the channel interfaces, scl_ctrl and scl_datapath.

// Each accepted request returns one uniform deviate as the integer numerator
// over 259200*134456 (first generator times 134456 plus second). A draw runs
// through the generator step (its first stage is already primed while idle),
// the scaling of the third generator to a table slot and the registered table
// read and refill, and ends with the result in the output register; the last
// step waits while that register holds a result not yet taken. A new request
// is taken only once the block is back in idle. The first request after
// reset, and any request with reseed set, first seeds the generators from the
// seed register and fills the table; the fill alternates a generator step with
// one slot write. One request is in work at a time; a finished result waits in
// the output register while the next request is taken. The seed register can
// be written at any cycle the block is idle and is always ready.
module shuffled_combined_lcg_uniform_unit #(
    parameter int TABLE_SIZE = scl_pkg::TABLE_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scl_req_if.sink          i_req,
    scl_rsp_if.source        o_rsp,
    scl_cfg_if.sink          i_cfg
);
    import scl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    // Sequencing.
    scl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_reseed (i_req.reseed),
        .o_req_ready  (i_req.ready),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    // Arithmetic and storage.
    scl_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_seed  (i_cfg.seed_magnitude),
        .o_deviate   (o_rsp.deviate_numerator)
    );

endmodule

// ===== rtl/scl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scl_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 97
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scl_lcg.sv =====
// One linear congruential generator with a pipelined step.
// Depends on scl_pkg; the modulus is taken with a reciprocal multiply.
module scl_lcg #(
    parameter longint unsigned MUL = scl_pkg::MUL_A,
    parameter longint unsigned INC = scl_pkg::INC_A,
    parameter longint unsigned MOD = scl_pkg::MOD_A
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [scl_pkg::LCG_W-1:0] i_load_value,
    input  logic                      i_step,
    output logic [scl_pkg::LCG_W-1:0] o_value
);
    import scl_pkg::*;

    // (MUL*x + INC) * RECIP folds into one multiply by a constant.
    localparam longint unsigned RECIP     = (64'd1 << RECIP_SHIFT) / MOD;
    localparam longint unsigned MUL_RECIP = MUL * RECIP;
    localparam longint unsigned INC_RECIP = INC * RECIP;

    logic [LCG_W-1:0]   r_x;
    logic [LCG_W-1:0]   n_x;
    logic [31:0]        r_v;
    logic [LCG_Q_W-1:0] r_q;
    logic [PROD_W-1:0]  q_prod;
    logic [31:0]        rem;
    logic [31:0]        rem_fix;

    // First stage: the linear term and the quotient estimate, refreshed every cycle.
    assign q_prod = PROD_W'(r_x) * PROD_W'(MUL_RECIP) + PROD_W'(INC_RECIP);

    always_ff @(posedge i_clk) begin
        r_v <= 32'(r_x) * 32'(MUL) + 32'(INC);
        r_q <= q_prod[RECIP_SHIFT +: LCG_Q_W];
    end

    // Second stage: remainder with one correction step.
    always_comb begin
        rem     = r_v - 32'(r_q) * 32'(MOD);
        rem_fix = (rem >= 32'(MOD)) ? rem - 32'(MOD) : rem;
    end

    // Generator state.
    always_comb begin
        n_x = r_x;
        if (i_load) begin
            n_x = i_load_value;
        end else if (i_step) begin
            n_x = rem_fix[LCG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    assign o_value = r_x;

endmodule

// ===== rtl/scl_datapath.sv =====
// Datapath: seed register, three generators, slot scaling, shuffle table and
// output register. Depends on scl_pkg, scl_lcg and scl_ram.
module scl_datapath #(
    parameter int TABLE_SIZE = scl_pkg::TABLE_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scl_pkg::t_dp_cmd           i_cmd,
    output scl_pkg::t_dp_sts           o_sts,
    input  logic                       i_cfg_valid,
    input  logic [scl_pkg::SEED_W-1:0] i_cfg_seed,
    output logic [scl_pkg::DEV_W-1:0]  o_deviate
);
    import scl_pkg::*;

    localparam int              IDX_W    = $clog2(TABLE_SIZE);
    localparam int              P_W      = LCG_W + IDX_W;
    localparam longint unsigned SLOT_MUL = TABLE_SIZE * SLOT_RECIP;

    logic [SEED_W-1:0]     r_seed_mag;
    logic [SEED_SUM_W-1:0] seed_sum;
    logic [PROD_W-1:0]     seed_prod;
    logic [SEED_SUM_W-1:0] r_seed_sum;
    logic [SEED_Q_W-1:0]   r_seed_q;
    logic [SEED_SUM_W-1:0] seed_rem;
    logic [SEED_SUM_W-1:0] seed_fix;

    logic [LCG_W-1:0] a_val;
    logic [LCG_W-1:0] b_val;
    logic [LCG_W-1:0] c_val;
    logic [LCG_W-1:0] a_mod_b;
    logic [LCG_W-1:0] a_mod_c;

    logic [PROD_W-1:0] sq_prod;
    logic [P_W-1:0]    r_sp;
    logic [IDX_W-1:0]  r_sq;
    logic [P_W-1:0]    slot_rem;
    logic [IDX_W-1:0]  n_slot;
    logic [IDX_W-1:0]  r_slot;

    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;

    logic [DEV_W-1:0] comb;
    logic [DEV_W-1:0] ram_rdata;
    logic [DEV_W-1:0] r_deviate;

    // Seed register, written from the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_mag <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed_mag <= i_cfg_seed;
        end
    end

    // Seed reduction: exact 32-bit sum, reciprocal quotient, one correction.
    always_comb begin
        seed_sum  = SEED_SUM_W'(INC_A) + SEED_SUM_W'(r_seed_mag);
        seed_prod = PROD_W'(seed_sum) * PROD_W'(SEED_RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_seed_sum <= seed_sum;
        r_seed_q   <= seed_prod[SEED_SHIFT +: SEED_Q_W];
    end

    always_comb begin
        seed_rem = r_seed_sum - SEED_SUM_W'(r_seed_q) * SEED_SUM_W'(MOD_A);
        seed_fix = (seed_rem >= SEED_SUM_W'(MOD_A)) ? seed_rem - SEED_SUM_W'(MOD_A)
                                                    : seed_rem;
    end

    // The first generator stays below twice either smaller modulus.
    always_comb begin
        a_mod_b = (a_val >= LCG_W'(MOD_B)) ? a_val - LCG_W'(MOD_B) : a_val;
        a_mod_c = (a_val >= LCG_W'(MOD_C)) ? a_val - LCG_W'(MOD_C) : a_val;
    end

    // The three generators.
    scl_lcg #(.MUL(MUL_A), .INC(INC_A), .MOD(MOD_A)) u_lcg_a (
        .i_clk        (i_clk),
        .i_load       (i_cmd.load_first),
        .i_load_value (seed_fix[LCG_W-1:0]),
        .i_step       (i_cmd.step_ab),
        .o_value      (a_val)
    );

    scl_lcg #(.MUL(MUL_B), .INC(INC_B), .MOD(MOD_B)) u_lcg_b (
        .i_clk        (i_clk),
        .i_load       (i_cmd.load_second),
        .i_load_value (a_mod_b),
        .i_step       (i_cmd.step_ab),
        .o_value      (b_val)
    );

    scl_lcg #(.MUL(MUL_C), .INC(INC_C), .MOD(MOD_C)) u_lcg_c (
        .i_clk        (i_clk),
        .i_load       (i_cmd.load_third),
        .i_load_value (a_mod_c),
        .i_step       (i_cmd.step_c),
        .o_value      (c_val)
    );

    // Slot scaling, stage one: scaled value and quotient estimate.
    assign sq_prod = PROD_W'(c_val) * PROD_W'(SLOT_MUL);

    always_ff @(posedge i_clk) begin
        r_sp <= P_W'(c_val) * P_W'(TABLE_SIZE);
        r_sq <= sq_prod[RECIP_SHIFT +: IDX_W];
    end

    // Slot scaling, stage two: bump the estimate when the remainder overflows.
    always_comb begin
        slot_rem = r_sp - P_W'(r_sq) * P_W'(MOD_C);
        n_slot   = r_sq + IDX_W'(slot_rem >= P_W'(MOD_C));
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    // Fill counter.
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.fill_wr) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_sts.cnt_last = (r_cnt == IDX_W'(TABLE_SIZE - 1));

    // Combined value of the first two generators.
    assign comb = DEV_W'(a_val) * DEV_W'(MOD_B) + DEV_W'(b_val);

    // Shuffle table.
    scl_ram #(.WIDTH(DEV_W), .DEPTH(TABLE_SIZE)) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill_wr | i_cmd.draw_done),
        .i_waddr (i_cmd.fill_wr ? r_cnt : r_slot),
        .i_wdata (comb),
        .i_re    (i_cmd.tbl_rd),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_done) begin
            r_deviate <= ram_rdata;
        end
    end

    assign o_deviate = r_deviate;

endmodule

// ===== rtl/scl_ctrl.sv =====
// Controller state machine: handshakes, seeding sequence and draw sequence.
// Depends on scl_pkg for the state type and the command/status structs.
module scl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_reseed,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output scl_pkg::t_dp_cmd o_cmd,
    input  scl_pkg::t_dp_sts i_sts
);
    import scl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_seeded;
    logic   n_seeded;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_rsp_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_reseed || !r_seeded) ? ST_SEED_WAIT : ST_DRAW_STEP;
                end
            end
            ST_SEED_WAIT:  n_state = ST_SEED_LOAD;
            ST_SEED_LOAD:  n_state = ST_SEED_HOLD;
            ST_SEED_HOLD:  n_state = ST_SEED_A1;
            ST_SEED_A1:    n_state = ST_SEED_B;
            ST_SEED_B:     n_state = ST_SEED_A2;
            ST_SEED_A2:    n_state = ST_SEED_C;
            ST_SEED_C:     n_state = ST_FILL_STEP;
            ST_FILL_STEP:  n_state = ST_FILL_WR;
            ST_FILL_WR: begin
                n_state = i_sts.cnt_last ? ST_DRAW_STEP : ST_FILL_STEP;
            end
            ST_DRAW_STEP:  n_state = ST_DRAW_SLOT1;
            ST_DRAW_SLOT1: n_state = ST_DRAW_SLOT2;
            ST_DRAW_SLOT2: n_state = ST_DRAW_READ;
            ST_DRAW_READ:  n_state = ST_DRAW_DONE;
            ST_DRAW_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // Datapath commands. A generator steps only when its first stage has
    // caught up with its current value, so a state without a step follows each change.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_SEED_LOAD:  o_cmd.load_first  = 1'b1;
            ST_SEED_A1:    o_cmd.step_ab     = 1'b1;
            ST_SEED_B:     o_cmd.load_second = 1'b1;
            ST_SEED_A2: begin
                // The second generator is loaded again so that it keeps its
                // seed while the first one takes its step.
                o_cmd.step_ab     = 1'b1;
                o_cmd.load_second = 1'b1;
            end
            ST_SEED_C: begin
                o_cmd.load_third = 1'b1;
                o_cmd.cnt_clr    = 1'b1;
            end
            ST_FILL_STEP:  o_cmd.step_ab     = 1'b1;
            ST_FILL_WR:    o_cmd.fill_wr     = 1'b1;
            ST_DRAW_STEP: begin
                o_cmd.step_ab = 1'b1;
                o_cmd.step_c  = 1'b1;
            end
            ST_DRAW_READ:  o_cmd.tbl_rd      = 1'b1;
            ST_DRAW_DONE:  o_cmd.draw_done   = out_free;
            default:       o_cmd = '0;
        endcase
    end

    // Seeded flag and output valid.
    always_comb begin
        n_seeded = r_seeded;
        if (r_state == ST_FILL_WR && i_sts.cnt_last) begin
            n_seeded = 1'b1;
        end
        n_out_valid = r_out_valid;
        if (r_state == ST_DRAW_DONE && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_out_valid;

endmodule

// ===== rtl/scl_checker.sv =====
// Port-level checks of the generator, attached to the top level by bind.
// Depends on scl_pkg for the result width.
module scl_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [scl_pkg::DEV_W-1:0] i_rsp_data
);
    import scl_pkg::*;

    localparam logic [DEV_W-1:0] DEV_MAX = 36'd34850995199;

    logic r_prev_valid;
    logic r_prev_ready;
    logic r_owed;
    logic n_owed;
    logic req_acc;
    logic new_res;

    // A new result shows when valid rises or follows a completed response.
    assign req_acc = i_req_valid && i_req_ready;
    assign new_res = i_rsp_valid && (!r_prev_valid || r_prev_ready);

    always_comb begin
        n_owed = r_owed;
        if (req_acc) begin
            n_owed = 1'b1;
        end else if (new_res) begin
            n_owed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_prev_ready <= 1'b0;
            r_owed       <= 1'b0;
        end else begin
            r_prev_valid <= i_rsp_valid;
            r_prev_ready <= i_rsp_ready;
            r_owed       <= n_owed;
        end
    end

    // A stalled response keeps its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response changed while stalled");

    // Every new result answers a request that has not been answered yet.
    a_rsp_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        new_res |-> r_owed)
        else $error("result without an outstanding request");

    // Results stay inside the numerator range.
    a_rsp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_data <= DEV_MAX)
        else $error("deviate numerator out of range");

    // A request is not taken again while the draw it started is in work.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req_ready ##1 !i_req_ready ##1 !i_req_ready
                    ##1 !i_req_ready ##1 !i_req_ready)
        else $error("request taken while a draw was in work");

endmodule

bind shuffled_combined_lcg_uniform_unit scl_checker u_scl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.deviate_numerator)
);

// ===== sim/tb_shuffled_combined_lcg_uniform_unit.sv =====
// Testbench for the shuffled three-LCG uniform generator: random request and response
// timing, seed register writes between phases, and a scoreboard that predicts every deviate.
// Depends on scl_pkg, the channel interfaces and the generator top level.
module tb_shuffled_combined_lcg_uniform_unit;
    import scl_pkg::*;

    typedef longint unsigned u64_t;

    localparam int   SLOTS       = TABLE_SIZE_DEF;
    localparam int   MAX_IDLE    = 18;
    localparam int   PHASES      = 10;
    localparam int   PHASE_ITEMS = 155;
    localparam u64_t CYCLE_LIMIT = 2000000;
    // Seed that makes the reduced seed sum land exactly on zero.
    localparam logic [SEED_W-1:0] SEED_TO_ZERO = SEED_W'(MOD_A - INC_A);

    // Predicts each deviate and compares the responses against the predictions in order.
    class lcg_scoreboard;
        logic [LCG_W-1:0]  gen_a;
        logic [LCG_W-1:0]  gen_b;
        logic [LCG_W-1:0]  gen_c;
        logic [DEV_W-1:0]  slots [SLOTS];
        bit                seeded;
        logic [SEED_W-1:0] seed;
        logic [DEV_W-1:0]  expected_deviates [$];
        int unsigned       mismatches;
        int unsigned       checked;

        function new();
            gen_a      = '0;
            gen_b      = '0;
            gen_c      = '0;
            seeded     = 1'b0;
            seed       = SEED_RESET;
            mismatches = 0;
            checked    = 0;
            foreach (slots[k]) slots[k] = '0;
        endfunction

        function logic [LCG_W-1:0] step_a(logic [LCG_W-1:0] x);
            return LCG_W'((MUL_A * u64_t'(x) + INC_A) % MOD_A);
        endfunction

        function logic [LCG_W-1:0] step_b(logic [LCG_W-1:0] x);
            return LCG_W'((MUL_B * u64_t'(x) + INC_B) % MOD_B);
        endfunction

        function logic [LCG_W-1:0] step_c(logic [LCG_W-1:0] x);
            return LCG_W'((MUL_C * u64_t'(x) + INC_C) % MOD_C);
        endfunction

        function logic [DEV_W-1:0] combined();
            return DEV_W'(u64_t'(gen_a) * MOD_B + u64_t'(gen_b));
        endfunction

        // Seed all three generators from the register, then fill every slot in order.
        function void restart_generators();
            u64_t sum;
            sum   = INC_A + u64_t'(seed);
            gen_a = LCG_W'(sum % MOD_A);
            gen_a = step_a(gen_a);
            gen_b = LCG_W'(u64_t'(gen_a) % MOD_B);
            gen_a = step_a(gen_a);
            gen_c = LCG_W'(u64_t'(gen_a) % MOD_C);
            for (int k = 0; k < SLOTS; k++) begin
                gen_a    = step_a(gen_a);
                gen_b    = step_b(gen_b);
                slots[k] = combined();
            end
            seeded = 1'b1;
        endfunction

        function void note_seed(logic [SEED_W-1:0] value);
            seed = value;
        endfunction

        // An accepted request: step the generators, return the picked slot, refill it.
        function void note_request(bit reseed);
            u64_t idx;
            if (reseed || !seeded) begin
                restart_generators();
            end
            gen_a = step_a(gen_a);
            gen_b = step_b(gen_b);
            gen_c = step_c(gen_c);
            idx = (u64_t'(SLOTS) * u64_t'(gen_c)) / MOD_C;
            if (idx >= SLOTS) begin
                idx = SLOTS - 1;
            end
            expected_deviates.push_back(slots[idx]);
            slots[idx] = combined();
        endfunction

        function int unsigned pending();
            return expected_deviates.size();
        endfunction

        task report(string msg);
            if (mismatches < 40) begin
                $display("MISMATCH: %s", msg);
            end
            mismatches++;
        endtask

        task check_deviate(logic [DEV_W-1:0] got);
            logic [DEV_W-1:0] want;
            if (expected_deviates.size() == 0) begin
                report($sformatf("deviate %0d arrived with no request outstanding", got));
            end else begin
                want = expected_deviates.pop_front();
                checked++;
                if (got !== want) begin
                    report($sformatf("deviate %0d, expected %0d", got, want));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    scl_req_if req_ch ();
    scl_rsp_if rsp_ch ();
    scl_cfg_if cfg_ch ();

    lcg_scoreboard deviate_sb = new();

    bit          no_idle;
    u64_t        cycle_count;
    int unsigned requests;
    int unsigned reseed_requests;
    int unsigned seed_writes;

    shuffled_combined_lcg_uniform_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d deviates outstanding.",
                 cycle_count, deviate_sb.pending());
        $display("simulation failed");
        $finish;
    end

    // Response side: stall a random number of cycles, then take one deviate and check it.
    initial begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end else begin
                @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            deviate_sb.check_deviate(rsp_ch.deviate_numerator);
        end
    end

    // Send one request after a random gap; valid stays high across back-to-back requests.
    task automatic send_request(bit reseed);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.reseed <= reseed;
        do @(posedge i_clk); while (!req_ch.ready);
        deviate_sb.note_request(reseed);
        requests++;
        if (reseed) begin
            reseed_requests++;
        end
    endtask

    // Stop requesting and wait until every predicted deviate has come back.
    task automatic drain_requests();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (deviate_sb.pending() > 0) @(posedge i_clk);
    endtask

    // Write the seed register; only called while the generator is idle.
    task automatic write_seed(logic [SEED_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.seed_magnitude <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        deviate_sb.note_seed(value);
        seed_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [SEED_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2:       return SEED_RESET;
            3:       return SEED_TO_ZERO;
            default: return SEED_W'($urandom);
        endcase
    endfunction

    // Main sequence.
    initial begin
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.reseed         = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.seed_magnitude = '0;
        no_idle               = 1'b0;
        requests              = 0;
        reseed_requests       = 0;
        seed_writes           = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first request seeds from the reset value of the register.
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain_requests();

        // Largest seed: the seed sum must not wrap.
        write_seed('1);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        drain_requests();

        // Zero seed, below the normal range, is used as written.
        write_seed('0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain_requests();

        // A seed write alone must not reseed; back-to-back reseeds follow.
        no_idle = 1'b1;
        write_seed(SEED_TO_ZERO);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain_requests();
        no_idle = 1'b0;

        // Random phases, each with a fresh seed and occasional reseeds.
        for (int p = 0; p < PHASES; p++) begin
            write_seed(pick_seed());
            no_idle = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0) begin
                    send_request(1'($urandom_range(0, 1)));
                end else begin
                    send_request($urandom_range(0, 19) == 0);
                end
            end
            drain_requests();
        end
        no_idle = 1'b0;

        // Let any stray deviate show up before the verdict.
        repeat (30) @(posedge i_clk);
        if (deviate_sb.pending() != 0) begin
            deviate_sb.report($sformatf("%0d deviates never arrived", deviate_sb.pending()));
        end

        $display("Sent %0d requests (%0d with reseed) across %0d seed settings.",
                 requests, reseed_requests, seed_writes + 1);
        $display("Checked %0d deviates, %0d mismatches.", deviate_sb.checked,
                 deviate_sb.mismatches);
        if (deviate_sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
